/* hw/rtl/sum_checked_frame_receiver_defines.svh */
// assertion macros of the frame receiver sources
`ifndef SUM_CHECKED_FRAME_RECEIVER_DEFINES_SVH
`define SUM_CHECKED_FRAME_RECEIVER_DEFINES_SVH

`ifndef SYNTHESIS

// concurrent check on a named clock and active-low reset
`define SCFR_ASSERT_CLK(lbl, clk_sig, rst_n_sig, prop, msg) \
	lbl: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) prop) \
		else $error(msg);

// concurrent check on the block clock and reset
`define SCFR_ASSERT(lbl, prop, msg) \
	`SCFR_ASSERT_CLK(lbl, clk, arst_n, prop, msg)

`else

`define SCFR_ASSERT_CLK(lbl, clk_sig, rst_n_sig, prop, msg)

`define SCFR_ASSERT(lbl, prop, msg)

`endif

`endif

/* hw/rtl/scfr_pkg.sv */
// types and constants of the frame receiver
package scfr_pkg;

	localparam int BYTE_W   = 8;
	localparam int STATUS_W = 2;
	localparam int VALUE_W  = 16;
	localparam int PHASE_W  = 3;

	localparam logic [BYTE_W-1:0] HEAD_A = 8'hAA;
	localparam logic [BYTE_W-1:0] HEAD_B = 8'h55;

	// parser phase codes
	localparam logic [PHASE_W-1:0] PH_HUNT    = 3'd0;
	localparam logic [PHASE_W-1:0] PH_LEN     = 3'd1;
	localparam logic [PHASE_W-1:0] PH_ID      = 3'd2;
	localparam logic [PHASE_W-1:0] PH_PAYLOAD = 3'd3;
	localparam logic [PHASE_W-1:0] PH_CHECK   = 3'd4;
	localparam logic [PHASE_W-1:0] PH_TRAIL1  = 3'd5;
	localparam logic [PHASE_W-1:0] PH_TRAIL2  = 3'd6;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_SUM   = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FRAME = 2'd2;

	typedef struct packed {
		logic [BYTE_W-1:0] rx_byte;
		logic              end_of_buffer;
	} rx_item_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [BYTE_W-1:0]   identifier;
		logic [BYTE_W-1:0]   payload_length;
		logic [VALUE_W-1:0]  payload_value;
	} result_t;

endpackage

/* hw/rtl/scfr_rx_if.sv */
// byte request channel into the frame receiver
interface scfr_rx_if;
	import scfr_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] rx_byte;
	logic              end_of_buffer;

	modport source(output valid, output rx_byte, output end_of_buffer, input ready);
	modport sink(input valid, input rx_byte, input end_of_buffer, output ready);
endinterface

/* hw/rtl/scfr_res_if.sv */
// frame result channel out of the frame receiver
interface scfr_res_if;
	import scfr_pkg::*;

	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [BYTE_W-1:0]   identifier;
	logic [BYTE_W-1:0]   payload_length;
	logic [VALUE_W-1:0]  payload_value;

	modport source(output valid, output status, output identifier,
		output payload_length, output payload_value, input ready);
	modport sink(input valid, input status, input identifier,
		input payload_length, input payload_value, output ready);
endinterface

/* hw/rtl/scfr_in_stage.sv */
// input register stage for received bytes
module scfr_in_stage (
	input  logic                clk,
	input  logic                arst_n,
	scfr_rx_if.sink             rx,
	input  logic                take,
	output logic                item_valid,
	output scfr_pkg::rx_item_t  item
);
	import scfr_pkg::*;

	logic     valid_s1;
	rx_item_t item_s1;

	// free when empty or when the held byte moves on this cycle
	assign rx.ready   = !valid_s1 || take;
	assign item_valid = valid_s1;
	assign item       = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			item_s1.rx_byte       <= rx.rx_byte;
			item_s1.end_of_buffer <= rx.end_of_buffer;
		end
	end
endmodule

/* hw/rtl/scfr_parser.sv */
// frame state and per-byte update logic
`include "sum_checked_frame_receiver_defines.svh"

module scfr_parser (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step_en,
	input  scfr_pkg::rx_item_t item,
	output logic               emit,
	output scfr_pkg::result_t  result
);
	import scfr_pkg::*;

	logic [PHASE_W-1:0] phase_q,   phase_d;
	logic [BYTE_W-1:0]  prev_q,    prev_d;
	logic [BYTE_W-1:0]  len_q,     len_d;
	logic [BYTE_W-1:0]  seen_q,    seen_d;
	logic [BYTE_W-1:0]  sum_q,     sum_d;
	logic [BYTE_W-1:0]  ident_q,   ident_d;
	logic [VALUE_W-1:0] first_q,   first_d;
	logic [BYTE_W-1:0]  rx_sum_q,  rx_sum_d;
	logic [STATUS_W-1:0] status;
	logic [BYTE_W-1:0]  b;
	logic [BYTE_W-1:0]  seen_inc;
	logic [BYTE_W-1:0]  sum_trail;
	logic               pair;

	assign b         = item.rx_byte;
	assign pair      = (prev_q == HEAD_B) && (b == HEAD_A);
	assign seen_inc  = seen_q + 8'd1;
	assign sum_trail = sum_q + HEAD_B + HEAD_A;

	always_comb begin
		phase_d  = phase_q;
		len_d    = len_q;
		seen_d   = seen_q;
		sum_d    = sum_q;
		ident_d  = ident_q;
		first_d  = first_q;
		rx_sum_d = rx_sum_q;
		emit     = 1'b0;
		status   = ST_OK;
		unique case (phase_q)
			PH_LEN: begin
				len_d   = b;
				sum_d   = sum_q + b;
				phase_d = PH_ID;
			end
			PH_ID: begin
				ident_d = b;
				sum_d   = sum_q + b;
				phase_d = (len_q == '0) ? PH_CHECK : PH_PAYLOAD;
			end
			PH_PAYLOAD: begin
				if (seen_q != '0 && pair) begin
					emit   = 1'b1;
					status = ST_FRAME;
				end else begin
					if (seen_q == 8'd0) begin
						first_d = {b, 8'h00};
					end else if (seen_q == 8'd1) begin
						first_d = first_q | {8'h00, b};
					end
					sum_d  = sum_q + b;
					seen_d = seen_inc;
					if (seen_inc == len_q) begin
						phase_d = PH_CHECK;
					end
				end
			end
			PH_CHECK: begin
				if (len_q != '0 && pair) begin
					emit   = 1'b1;
					status = ST_FRAME;
				end else begin
					rx_sum_d = b;
					phase_d  = PH_TRAIL1;
				end
			end
			PH_TRAIL1: begin
				if (pair) begin
					emit   = 1'b1;
					status = ST_FRAME;
				end else begin
					phase_d = PH_TRAIL2;
				end
			end
			PH_TRAIL2: begin
				emit = 1'b1;
				if (!pair) begin
					status = ST_FRAME;
				end else if (sum_trail == rx_sum_q) begin
					status = ST_OK;
				end else begin
					status = ST_SUM;
				end
			end
			default: begin
				// hunt, and the unused code behaves the same
				if (prev_q == HEAD_A && b == HEAD_B) begin
					phase_d  = PH_LEN;
					len_d    = '0;
					seen_d   = '0;
					ident_d  = '0;
					first_d  = '0;
					rx_sum_d = '0;
					sum_d    = HEAD_A + HEAD_B;
				end else begin
					phase_d = PH_HUNT;
				end
			end
		endcase
		if (emit || item.end_of_buffer) begin
			phase_d = PH_HUNT;
			prev_d  = '0;
		end else begin
			prev_d  = b;
		end
	end

	// result reports the frame fields as they stood before this byte
	assign result.status         = status;
	assign result.identifier     = ident_q;
	assign result.payload_length = len_q;
	assign result.payload_value  = first_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HUNT;
			prev_q   <= '0;
			len_q    <= '0;
			seen_q   <= '0;
			sum_q    <= '0;
			ident_q  <= '0;
			first_q  <= '0;
			rx_sum_q <= '0;
		end else if (step_en) begin
			phase_q  <= phase_d;
			prev_q   <= prev_d;
			len_q    <= len_d;
			seen_q   <= seen_d;
			sum_q    <= sum_d;
			ident_q  <= ident_d;
			first_q  <= first_d;
			rx_sum_q <= rx_sum_d;
		end
	end

	`SCFR_ASSERT(a_emit_rehunt, (step_en && emit) |=> (phase_q == PH_HUNT && prev_q == '0), "result must restart the header hunt")
	`SCFR_ASSERT(a_eob_drop, (step_en && item.end_of_buffer) |=> (phase_q == PH_HUNT), "end of buffer must drop the frame")
	`SCFR_ASSERT(a_payload_count, (phase_q == PH_PAYLOAD) |-> (seen_q < len_q), "payload count ran past the length")
endmodule

/* hw/rtl/scfr_res_reg.sv */
// result output register
module scfr_res_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  scfr_pkg::result_t result,
	output logic              can_take,
	scfr_res_if.source        res
);
	import scfr_pkg::*;

	logic    valid_q;
	result_t result_q;

	assign can_take           = !valid_q || res.ready;
	assign res.valid          = valid_q;
	assign res.status         = result_q.status;
	assign res.identifier     = result_q.identifier;
	assign res.payload_length = result_q.payload_length;
	assign res.payload_value  = result_q.payload_value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (can_take) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (can_take && load) begin
			result_q <= result;
		end
	end
endmodule

/* hw/rtl/sum_checked_frame_receiver.sv */
// top level of the header/length/checksum/trailer frame receiver
//
// channel  dir  payload                                             handshake
// rx       in   rx_byte[7:0], end_of_buffer                         valid/ready
// res      out  status[1:0], identifier[7:0], payload_length[7:0],  valid/ready
//              payload_value[15:0]
//
// one byte request per cycle when the result side keeps up
// byte sits in the input register, the frame update and the result are one
//   level of logic into the state and result registers
// a held result stalls the parser and the input register, so at most one more byte is taken
// async reset puts the parser in header hunt with all frame fields zero
module sum_checked_frame_receiver (
	input  logic       clk,
	input  logic       arst_n,
	scfr_rx_if.sink    rx,
	scfr_res_if.source res
);
	import scfr_pkg::*;

	rx_item_t item;
	result_t  result;
	logic     item_valid;
	logic     take;
	logic     emit;
	logic     can_take;

	// the held byte steps the parser when the result register has room
	assign take = item_valid && can_take;

	scfr_in_stage u_in (
		.clk        (clk),
		.arst_n     (arst_n),
		.rx         (rx),
		.take       (take),
		.item_valid (item_valid),
		.item       (item)
	);

	// frame state machine, checksum and field capture
	scfr_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (take),
		.item    (item),
		.emit    (emit),
		.result  (result)
	);

	// only a finishing byte loads a result
	scfr_res_reg u_res (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (take && emit),
		.result   (result),
		.can_take (can_take),
		.res      (res)
	);
endmodule

/* tb/testbench.sv */
// self-checking testbench of the frame receiver: directed byte script, then random frames
`timescale 1ns / 1ps

module testbench;
	import scfr_pkg::*;

	localparam int CYCLE_LIMIT   = 200000;
	// the script and the long frame bring the run to about 600 bytes
	localparam int RANDOM_ITEMS  = 300;
	// lets the block drain before the verdict, with margin
	localparam int SETTLE_CYCLES = 8;
	localparam int SCRIPT_ROWS   = 26;

	// one byte of the directed script; a typed row carries its own expected frame
	typedef struct {
		logic [BYTE_W-1:0] rx_byte;
		logic              eob;
		bit                typed;
		result_t           want;
	} script_row_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	scfr_rx_if  rx_ch();
	scfr_res_if res_ch();

	sum_checked_frame_receiver u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_ch),
		.res    (res_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// parser state of the predictor
	logic [PHASE_W-1:0]  phase_q = PH_HUNT;
	logic [BYTE_W-1:0]   prev_q  = '0;
	logic [BYTE_W-1:0]   len_q   = '0;
	logic [BYTE_W-1:0]   taken_q = '0;
	logic [BYTE_W-1:0]   sum_q   = '0;
	logic [BYTE_W-1:0]   id_q    = '0;
	logic [BYTE_W-1:0]   ck_q    = '0;
	logic [VALUE_W-1:0]  first_q = '0;

	result_t frames_due[$];
	int      errors     = 0;
	int      items_sent = 0;
	int      cycles     = 0;
	int      gap_pct    = 0;
	int      stall_pct  = 0;

	// directed script: good frame, lone 55 after a result, zero length with bad sum,
	// early 55 AA inside the payload, then a header split by end of buffer
	script_row_t byte_script [SCRIPT_ROWS] = '{
		'{8'hAA, 1'b0, 1'b0, '0},
		'{8'h55, 1'b0, 1'b0, '0},
		'{8'h02, 1'b0, 1'b0, '0},
		'{8'h11, 1'b0, 1'b0, '0},
		'{8'h12, 1'b0, 1'b0, '0},
		'{8'h34, 1'b0, 1'b0, '0},
		'{8'h57, 1'b0, 1'b0, '0},
		'{8'h55, 1'b0, 1'b0, '0},
		'{8'hAA, 1'b0, 1'b1, '{ST_OK, 8'h11, 8'h02, 16'h1234}},
		'{8'h55, 1'b0, 1'b0, '0},
		'{8'hAA, 1'b0, 1'b0, '0},
		'{8'h55, 1'b0, 1'b0, '0},
		'{8'h00, 1'b0, 1'b0, '0},
		'{8'h7F, 1'b0, 1'b0, '0},
		'{8'h00, 1'b0, 1'b0, '0},
		'{8'h55, 1'b0, 1'b0, '0},
		'{8'hAA, 1'b0, 1'b1, '{ST_SUM, 8'h7F, 8'h00, 16'h0000}},
		'{8'hAA, 1'b0, 1'b0, '0},
		'{8'h55, 1'b0, 1'b0, '0},
		'{8'h05, 1'b0, 1'b0, '0},
		'{8'h22, 1'b0, 1'b0, '0},
		'{8'h01, 1'b0, 1'b0, '0},
		'{8'h55, 1'b0, 1'b0, '0},
		'{8'hAA, 1'b0, 1'b1, '{ST_FRAME, 8'h22, 8'h05, 16'h0155}},
		'{8'hAA, 1'b1, 1'b0, '0},
		'{8'h55, 1'b0, 1'b0, '0}
	};

	// advance the predicted parser by one byte, returns 1 when a frame result falls out
	function automatic bit parse_byte(input logic [BYTE_W-1:0] b, input logic eob,
		output result_t r);
		logic                pair;
		logic                hit;
		logic [STATUS_W-1:0] st;
		logic [BYTE_W-1:0]   tot;
		pair = (prev_q == HEAD_B) && (b == HEAD_A);
		hit  = 1'b0;
		st   = ST_OK;
		case (phase_q)
			PH_LEN: begin
				len_q   = b;
				sum_q   = sum_q + b;
				phase_q = PH_ID;
			end
			PH_ID: begin
				id_q    = b;
				sum_q   = sum_q + b;
				phase_q = (len_q == 0) ? PH_CHECK : PH_PAYLOAD;
			end
			PH_PAYLOAD: begin
				// 55 AA once a payload byte is in: trailer came too early
				if (taken_q != 0 && pair) begin
					hit = 1'b1;
					st  = ST_FRAME;
				end else begin
					if (taken_q == 0)
						first_q = {b, 8'h00};
					else if (taken_q == 1)
						first_q = first_q | {8'h00, b};
					sum_q   = sum_q + b;
					taken_q = taken_q + 8'd1;
					if (taken_q == len_q)
						phase_q = PH_CHECK;
				end
			end
			PH_CHECK: begin
				if (len_q != 0 && pair) begin
					hit = 1'b1;
					st  = ST_FRAME;
				end else begin
					ck_q    = b;
					phase_q = PH_TRAIL1;
				end
			end
			PH_TRAIL1: begin
				if (pair) begin
					hit = 1'b1;
					st  = ST_FRAME;
				end else
					phase_q = PH_TRAIL2;
			end
			PH_TRAIL2: begin
				// trailer is judged before the checksum
				tot = sum_q + HEAD_B + HEAD_A;
				hit = 1'b1;
				st  = !pair ? ST_FRAME : (tot == ck_q) ? ST_OK : ST_SUM;
			end
			default: begin
				// hunting, the unused code included
				if (prev_q == HEAD_A && b == HEAD_B) begin
					phase_q = PH_LEN;
					len_q   = '0;
					taken_q = '0;
					id_q    = '0;
					first_q = '0;
					ck_q    = '0;
					sum_q   = HEAD_A + HEAD_B;
				end else
					phase_q = PH_HUNT;
			end
		endcase
		r = '{st, id_q, len_q, first_q};
		// a result or end of buffer restarts the hunt with a clean previous byte
		if (hit || eob) begin
			phase_q = PH_HUNT;
			prev_q  = '0;
		end else
			prev_q = b;
		return hit;
	endfunction

	// offer one byte request, maybe after idle cycles, and predict once it is taken
	task automatic push_byte(input logic [BYTE_W-1:0] b, input logic eob,
		input bit typed = 1'b0, input result_t want = '0);
		result_t got;
		bit      hit;
		// each cycle idles with the chance gap_pct
		while ($urandom_range(99) < gap_pct) begin
			rx_ch.valid <= 1'b0;
			@(posedge clk);
		end
		rx_ch.valid         <= 1'b1;
		rx_ch.rx_byte       <= b;
		rx_ch.end_of_buffer <= eob;
		do @(posedge clk); while (!rx_ch.ready);
		items_sent++;
		hit = parse_byte(b, eob, got);
		if (hit || typed)
			frames_due.push_back(typed ? want : got);
	endtask

	// stop sending until every predicted frame result has come back
	task automatic wait_for_results();
		rx_ch.valid <= 1'b0;
		@(posedge clk);
		while (frames_due.size() != 0)
			@(posedge clk);
	endtask

	// one frame with random content, mostly well formed, sometimes broken
	task automatic random_frame(input int plen);
		logic [BYTE_W-1:0] body[$];
		logic [BYTE_W-1:0] tot;
		int                fault;
		int                stop;
		int                idx;
		logic              last_eob;
		body = {HEAD_A, HEAD_B, 8'(plen), 8'($urandom)};
		// payload biased toward the marker bytes
		repeat (plen)
			body.push_back(($urandom_range(7) == 0) ?
				($urandom_range(1) ? HEAD_B : HEAD_A) : 8'($urandom));
		tot = '0;
		foreach (body[i])
			tot = tot + body[i];
		tot = tot + HEAD_B + HEAD_A;
		body.push_back(tot);
		body.push_back(HEAD_B);
		body.push_back(HEAD_A);
		fault = $urandom_range(99);
		stop  = body.size();
		if (fault >= 88) begin
			// cut short by end of buffer
			stop = $urandom_range(1, body.size() - 1);
		end else if (fault >= 76) begin
			// wrong trailer byte
			idx = body.size() - 1 - $urandom_range(1);
			body[idx] = body[idx] ^ 8'($urandom_range(1, 255));
		end else if (fault >= 60) begin
			// wrong checksum
			idx = body.size() - 3;
			body[idx] = body[idx] ^ 8'($urandom_range(1, 255));
		end else if (fault >= 52) begin
			// 55 AA somewhere from the first payload byte up to the first trailer byte
			idx = $urandom_range(4, body.size() - 3);
			body[idx]     = HEAD_B;
			body[idx + 1] = HEAD_A;
		end
		last_eob = (fault >= 88) || ($urandom_range(99) < 10);
		for (int i = 0; i < stop; i++)
			push_byte(body[i], last_eob && (i == stop - 1));
	endtask

	task automatic check_field(input string fname, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			errors++;
			$display("%0t mismatch %s: expected %0h, actual %0h", $time, fname, want, got);
		end
	endtask

	// result side stalls at random
	always @(posedge clk)
		res_ch.ready <= ($urandom_range(99) >= stall_pct);

	// compare every frame result with the oldest prediction
	always @(posedge clk) begin
		result_t seen;
		result_t due;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			seen = '{res_ch.status, res_ch.identifier, res_ch.payload_length,
				res_ch.payload_value};
			if (frames_due.size() == 0) begin
				errors++;
				$display("%0t mismatch: expected no result, actual status %0d id %02h len %0d value %04h",
					$time, seen.status, seen.identifier, seen.payload_length,
					seen.payload_value);
			end else begin
				due = frames_due.pop_front();
				check_field("status", due.status, seen.status);
				check_field("identifier", due.identifier, seen.identifier);
				check_field("payload_length", due.payload_length, seen.payload_length);
				check_field("payload_value", due.payload_value, seen.payload_value);
			end
		end
	end

	// hang guard
	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("testbench NOT OK");
			$finish;
		end
	end

	initial begin
		int target;
		rx_ch.valid         = 1'b0;
		rx_ch.rx_byte       = '0;
		rx_ch.end_of_buffer = 1'b0;
		res_ch.ready        = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		gap_pct   = 30;
		stall_pct = 84;
		foreach (byte_script[i])
			push_byte(byte_script[i].rx_byte, byte_script[i].eob, byte_script[i].typed,
				byte_script[i].want);
		wait_for_results();

		// longest frame once, the rest short
		random_frame(255);

		for (int mode = 0; mode < 3; mode++) begin
			gap_pct   = (mode == 0) ? 30 : (mode == 1) ? 84 : 0;
			stall_pct = (mode == 0) ? 84 : (mode == 1) ? 30 : 0;
			target    = items_sent + RANDOM_ITEMS / 3;
			while (items_sent < target) begin
				// line noise between frames, now and then ending a buffer
				repeat ($urandom_range(0, 3))
					push_byte(($urandom_range(3) == 0) ?
						($urandom_range(1) ? HEAD_A : HEAD_B) : 8'($urandom),
						$urandom_range(19) == 0);
				random_frame(($urandom_range(19) == 0) ?
					$urandom_range(7, 40) : $urandom_range(0, 6));
			end
			wait_for_results();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/scfr_pkg.sv
hw/rtl/scfr_rx_if.sv
hw/rtl/scfr_res_if.sv
hw/rtl/scfr_in_stage.sv
hw/rtl/scfr_parser.sv
hw/rtl/scfr_res_reg.sv
hw/rtl/sum_checked_frame_receiver.sv
tb/testbench.sv
